// ----- sv/p2prm_pkg.sv -----
// shared constants and types for the peak-to-peak running median block
`default_nettype none
package p2prm_pkg;

  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 12;
  localparam int AGE_BITS    = $clog2(WINDOW);
  localparam int CNT_BITS    = $clog2(WINDOW + 1);

  typedef logic [SAMPLE_BITS-1:0] value_t;
  typedef logic [AGE_BITS-1:0]    age_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  localparam age_t OLDEST_AGE = age_t'(WINDOW - 1);
  localparam cnt_t FULL_COUNT = cnt_t'(WINDOW);

  // entry held by a cell, seen by its left neighbor
  typedef struct packed {
    value_t value;
    age_t   age;
  } entry_t;

  // chain data handed from a cell to its right neighbor
  typedef struct packed {
    logic   evicted;
    logic   placed;
    value_t value;
    age_t   age;
  } link_t;

  // per-cell control from the top level
  typedef struct packed {
    logic   push;
    logic   occ_old;
    logic   occ_new;
    value_t value;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- sv/p2prm_if.sv -----
// valid/ready channel interfaces for sample input and result output
`default_nettype none
interface p2prm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  p2prm_pkg::value_t          sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface p2prm_out_if;
  logic                       valid;
  logic                       ready;
  p2prm_pkg::value_t          peak_to_peak;
  p2prm_pkg::value_t          median;

  modport source (output valid, output peak_to_peak, output median, input ready);
  modport sink   (input valid, input peak_to_peak, input median, output ready);
endinterface
`default_nettype wire

// ----- sv/peak_to_peak_running_median_top.sv -----
// top level of the peak-to-peak running median block
// in_ch_i carries beats with operation and sample. operation 0 is an ADC
// sample that updates the running max and min; operation 1 ends a window.
// a window end forms max minus min, clears the trackers and, if that value
// is non-zero, inserts it into a chain of WINDOW sorted cells, evicting
// the oldest entry when full. out_ch_o then carries one beat with the
// inserted peak-to-peak value and the lower median of the held values.
// sample beats and window ends with a zero value leave the input ready.
// a window end that inserts updates the cell chain when the beat is taken;
// the median is then read from the cells into the output register in the
// read state, which waits while a pending result is not yet taken.
// the output register decouples the sides: while a result waits, sample
// beats are still taken; a second inserting window end waits in the read
// state until the receiver takes the pending result.
// reset clears the trackers, the fill count and the output valid; cell
// contents are not cleared and are only read below the fill count.
`default_nettype none
module peak_to_peak_running_median_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  p2prm_in_if.sink           in_ch_i,
  p2prm_out_if.source        out_ch_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                    state_q, state_d;
  p2prm_pkg::cnt_t         fill_q, fill_d;
  p2prm_pkg::cnt_t         keep_count;
  p2prm_pkg::value_t       p2p;
  p2prm_pkg::value_t       p2p_q, p2p_d;
  p2prm_pkg::value_t       peak_q, peak_d;
  p2prm_pkg::value_t       median_q, median_d;
  p2prm_pkg::value_t       median_sel;
  p2prm_pkg::cnt_t         median_idx;
  logic                    out_valid_q, out_valid_d;
  logic                    accept;
  logic                    push;
  logic                    load;

  p2prm_pkg::ctrl_t        ctrl  [p2prm_pkg::WINDOW];
  p2prm_pkg::link_t        link  [p2prm_pkg::WINDOW+1];
  p2prm_pkg::entry_t       entry [p2prm_pkg::WINDOW+1];

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign accept        = in_ch_i.valid && in_ch_i.ready;
  assign push          = accept && in_ch_i.operation && (p2p != '0);

  p2prm_range u_range (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_en_i (accept && !in_ch_i.operation),
    .sample_i    (in_ch_i.sample),
    .clear_i     (accept && in_ch_i.operation),
    .p2p_o       (p2p)
  );

  assign keep_count = (fill_q == p2prm_pkg::FULL_COUNT) ?
                      (fill_q - p2prm_pkg::cnt_t'(1)) : fill_q;

  always_comb begin
    for (int i = 0; i < p2prm_pkg::WINDOW; i++) begin
      ctrl[i].push    = push;
      ctrl[i].occ_old = p2prm_pkg::cnt_t'(i) < fill_q;
      ctrl[i].occ_new = p2prm_pkg::cnt_t'(i) < keep_count;
      ctrl[i].value   = p2p;
    end
  end

  assign link[0]                   = '0;
  assign entry[p2prm_pkg::WINDOW]  = '0;

  for (genvar g = 0; g < p2prm_pkg::WINDOW; g++) begin : g_cell
    p2prm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .left_i  (link[g]),
      .right_i (entry[g+1]),
      .link_o  (link[g+1]),
      .entry_o (entry[g])
    );
  end

  // lower median sits at index fill/2 from the largest
  assign median_idx = fill_q >> 1;

  always_comb begin
    median_sel = '0;
    for (int i = 0; i < p2prm_pkg::WINDOW; i++) begin
      if (median_idx == p2prm_pkg::cnt_t'(i)) median_sel = entry[i].value;
    end
  end

  assign load = (state_q == ST_READ) && (!out_valid_q || out_ch_o.ready);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    p2p_d       = p2p_q;
    peak_d      = peak_q;
    median_d    = median_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ch_o.ready) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (push) begin
          p2p_d   = p2p;
          fill_d  = keep_count + p2prm_pkg::cnt_t'(1);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (load) begin
          peak_d      = p2p_q;
          median_d    = median_sel;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p2p_q    <= p2p_d;
    peak_q   <= peak_d;
    median_q <= median_d;
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.peak_to_peak = peak_q;
  assign out_ch_o.median       = median_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= p2prm_pkg::FULL_COUNT)
    else $error("fill count above window");

  a_push_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (fill_q != '0) && (state_q == ST_READ))
    else $error("insert did not update fill count or state");

  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ))
    else $error("result raised outside read cycle");

  a_result_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (peak_q != '0) && (median_q != '0))
    else $error("result carries a zero value");

  for (genvar g = 0; g + 1 < p2prm_pkg::WINDOW; g++) begin : g_sorted_chk
    a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (p2prm_pkg::cnt_t'(g + 1) < fill_q) |-> (entry[g].value >= entry[g+1].value))
      else $error("cell chain out of order");
  end

endmodule
`default_nettype wire

// ----- sv/p2prm_range.sv -----
// running maximum and minimum tracker with peak-to-peak output
`default_nettype none
module p2prm_range (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              sample_en_i,
  input  wire p2prm_pkg::value_t sample_i,
  input  wire logic              clear_i,
  output p2prm_pkg::value_t      p2p_o
);

  p2prm_pkg::value_t max_q, max_d;
  p2prm_pkg::value_t min_q, min_d;

  always_comb begin
    max_d = max_q;
    min_d = min_q;
    if (clear_i) begin
      max_d = '0;
      min_d = '1;
    end else if (sample_en_i) begin
      if (sample_i > max_q) max_d = sample_i;
      if (sample_i < min_q) min_d = sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= '1;
    end else begin
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  assign p2p_o = (max_q > min_q) ? (max_q - min_q) : '0;

endmodule
`default_nettype wire

// ----- sv/p2prm_cell.sv -----
// one cell of the sorted window chain: evicts, shifts and inserts
`default_nettype none
module p2prm_cell (
  input  wire logic               clk_i,
  input  wire p2prm_pkg::ctrl_t   ctrl_i,
  input  wire p2prm_pkg::link_t   left_i,
  input  wire p2prm_pkg::entry_t  right_i,
  output p2prm_pkg::link_t        link_o,
  output p2prm_pkg::entry_t       entry_o
);

  p2prm_pkg::value_t value_q, value_d;
  p2prm_pkg::age_t   age_q, age_d;

  logic              evict;
  logic              evicted;
  logic              placed;
  p2prm_pkg::value_t c_value;
  p2prm_pkg::age_t   c_age;

  always_comb begin
    evict   = ctrl_i.occ_old && (age_q == p2prm_pkg::OLDEST_AGE);
    evicted = left_i.evicted || evict;
    // compacted list entry at this position
    c_value = evicted ? right_i.value : value_q;
    c_age   = evicted ? right_i.age : age_q;
    placed  = !ctrl_i.occ_new || (c_value < ctrl_i.value);

    value_d = value_q;
    age_d   = age_q;
    if (ctrl_i.push) begin
      if (!placed) begin
        value_d = c_value;
        age_d   = c_age + p2prm_pkg::age_t'(1);
      end else if (!left_i.placed) begin
        value_d = ctrl_i.value;
        age_d   = '0;
      end else begin
        value_d = left_i.value;
        age_d   = left_i.age + p2prm_pkg::age_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  assign link_o  = '{evicted: evicted, placed: placed, value: c_value, age: c_age};
  assign entry_o = '{value: value_q, age: age_q};

endmodule
`default_nettype wire
